FILE: design/scale_weight_zero_tracker_defines.svh
// Assertion macros shared by the block's RTL files.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SCALE_WEIGHT_ZERO_TRACKER_DEFINES_SVH
`define SCALE_WEIGHT_ZERO_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define SWZT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SWZT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWZT_ASSERT(lbl, prop, msg)
`define SWZT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/swzt_pkg.sv
package swzt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned TRACK_DEPTH_DEF = 10;
  localparam int unsigned WARMUP_DEF      = 20;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths
  localparam int unsigned Q8_W   = 40;        // signed Q32.8 weight
  localparam int unsigned MUL_W  = 33;        // shared multiplier operand width
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ZB_Q_W = 18;        // capacity / 100
  localparam int unsigned BAND_W = 25;        // zero band bound

  // Constants of the weighing rules
  localparam logic signed [23:0] ADC_LIMIT = 24'sd4000000;
  localparam logic [24:0] RECIP_100       = 25'd21474837;  // ceil(2^31 / 100)
  localparam int unsigned RECIP_SHIFT     = 31;
  localparam logic [6:0] TRACK_RANGE_MAX  = 7'd100;
  localparam int unsigned OVER_DIVS       = 9;
  localparam int unsigned UNDER_DIVS      = 20;
  localparam int unsigned QUARTER_SHIFT   = 6;   // a quarter division in Q8
  localparam int unsigned HALF_UNIT       = 128; // 0.5 in Q8

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TRACK  = 2'd1,
    OP_ZERO   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_OFFSET   = 3'd0,
    REG_CAL_GAIN     = 3'd1,
    REG_DIVISION     = 3'd2,
    REG_CAPACITY     = 3'd3,
    REG_ZERO_BAND    = 3'd4,
    REG_TRACK_RANGE  = 3'd5,
    REG_SECOND_RANGE = 3'd6
  } reg_index_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMP_MUL,
    S_SMP_CAL,
    S_SMP_NET,
    S_SMP_RND,
    S_SMP_SAT,
    S_SMP_FLG,
    S_FILL,
    S_WRITE,
    S_LIM,
    S_SCAN,
    S_TRK_ADD,
    S_ZDIV,
    S_ZBAND,
    S_ZCMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [23:0] cal_offset;
    logic signed [31:0] cal_gain;
    logic [9:0]         division;
    logic [23:0]        capacity;
    logic [6:0]         zero_band_percent;
    logic [6:0]         track_range;
    logic [23:0]        second_range;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cal_offset:        24'sd0,
    cal_gain:          32'sd16777216,
    division:          10'd1,
    capacity:          24'd0,
    zero_band_percent: 7'd2,
    track_range:       7'd0,
    second_range:      24'd0
  };

  typedef struct packed {
    opcode_e            opcode;
    logic signed [23:0] adc_code;
    logic               stable;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic               zero_flag;
    logic               adc_over;
    logic               gross_over;
    logic               gross_under;
    logic               high_range;
    logic               ready_res;
    logic               tracked;
    logic               zero_refused;
  } result_t;

  typedef struct packed {
    logic idle;
    logic fin;
  } core_ctl_t;

  // Clamp a 41-bit sum to the signed 40-bit Q32.8 range
  function automatic logic signed [Q8_W-1:0] sat_q8(input logic signed [Q8_W:0] v);
    logic signed [Q8_W-1:0] r;
    if (v[Q8_W] != v[Q8_W-1]) begin
      r = v[Q8_W] ? {1'b1, {(Q8_W-1){1'b0}}} : {1'b0, {(Q8_W-1){1'b1}}};
    end else begin
      r = v[Q8_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/swzt_if.sv
// Sample/command channel
interface swzt_in_if;
  logic               valid;
  logic               ready;
  swzt_pkg::opcode_e  opcode;
  logic signed [23:0] adc_code;
  logic               stable;
  modport source(output valid, opcode, adc_code, stable, input ready);
  modport sink(input valid, opcode, adc_code, stable, output ready);
endinterface

// Result channel
interface swzt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight;
  logic               zero_flag;
  logic               adc_over;
  logic               gross_over;
  logic               gross_under;
  logic               high_range;
  logic               ready_res;
  logic               tracked;
  logic               zero_refused;
  modport source(output valid, weight, zero_flag, adc_over, gross_over, gross_under,
                 high_range, ready_res, tracked, zero_refused, input ready);
  modport sink(input valid, weight, zero_flag, adc_over, gross_over, gross_under,
               high_range, ready_res, tracked, zero_refused, output ready);
endinterface

// Register write channel
interface swzt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [swzt_pkg::CFG_IDX_W-1:0]      index;
  logic [swzt_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/swzt_mul.sv
// Shared signed multiplier with a registered product
module swzt_mul (
  input  logic                                  clk_i,
  input  logic signed [swzt_pkg::MUL_W-1:0]     a_i,
  input  logic signed [swzt_pkg::MUL_W-1:0]     b_i,
  output logic signed [swzt_pkg::PROD_W-1:0]    p_o
);

  logic signed [swzt_pkg::PROD_W-1:0] p_q;

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: design/swzt_win.sv
// Tracking window store: one write port, one registered read port
module swzt_win #(
  parameter int unsigned DEPTH = swzt_pkg::TRACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [swzt_pkg::Q8_W-1:0]    wr_data_i,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [swzt_pkg::Q8_W-1:0]    rd_data_o
);

  logic signed [swzt_pkg::Q8_W-1:0] mem_q [DEPTH];
  logic signed [swzt_pkg::Q8_W-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/swzt_core.sv
`include "scale_weight_zero_tracker_defines.svh"

// Sequencer and state of the weighing front end
module swzt_core #(
  parameter int unsigned TRACK_DEPTH    = swzt_pkg::TRACK_DEPTH_DEF,
  parameter int unsigned WARMUP_SAMPLES = swzt_pkg::WARMUP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  swzt_pkg::in_item_t   item_i,
  input  swzt_pkg::cfg_t       cfg_i,
  input  logic                 out_free_i,
  output swzt_pkg::core_ctl_t  ctl_o,
  output swzt_pkg::result_t    res_o
);

  localparam int unsigned QW     = swzt_pkg::Q8_W;
  localparam int unsigned MW     = swzt_pkg::MUL_W;
  localparam int unsigned PW     = $clog2(TRACK_DEPTH);
  localparam int unsigned WARM_W = (WARMUP_SAMPLES > 0) ? $clog2(WARMUP_SAMPLES + 1) : 1;
  localparam logic [PW-1:0]     LAST_IDX  = PW'(TRACK_DEPTH - 1);
  localparam logic [WARM_W-1:0] WARM_INIT = WARM_W'(WARMUP_SAMPLES);

  swzt_pkg::state_e state_q, state_d;

  // Architectural state
  logic signed [QW-1:0] zo_q, zo_d;
  logic signed [QW-1:0] net_q, net_d;
  logic [PW-1:0]        ptr_q, ptr_d;
  logic                 filled_q, filled_d;
  logic [WARM_W-1:0]    warm_q, warm_d;
  swzt_pkg::result_t    res_q, res_d;

  // Working registers
  logic signed [23:0]   code_q, code_d;
  logic signed [24:0]   diff_q, diff_d;
  logic                 stable_q, stable_d;
  logic signed [QW:0]   acc_q, acc_d;
  logic [24:0]          lim_hi_q, lim_hi_d;
  logic [14:0]          lim_lo_q, lim_lo_d;
  logic [24:0]          lim10_q, lim10_d;
  logic                 ok_q, ok_d;
  logic [PW-1:0]        idx_q, idx_d;

  // Shared multiplier and window store
  logic signed [MW-1:0]                mul_a, mul_b;
  logic signed [swzt_pkg::PROD_W-1:0]  prod;
  logic                                wr_en;
  logic [PW-1:0]                       wr_addr, rd_addr;
  logic signed [QW-1:0]                rd_data;

  swzt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  swzt_win #(
    .DEPTH (TRACK_DEPTH)
  ) u_win (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (net_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Calibrated value: round the Q.24 product to Q8
  logic [56:0]          cal_sum;
  logic signed [QW:0]   net_diff;
  logic signed [QW:0]   zo_sum;
  assign cal_sum  = prod[56:0] + 57'd32768;
  assign net_diff = acc_q - {zo_q[QW-1], zo_q};
  assign zo_sum   = {zo_q[QW-1], zo_q} + {net_q[QW-1], net_q};

  // Quarter-division zero band
  logic signed [QW:0] lim64_s, net_ext;
  logic               zero_in;
  assign lim64_s = {{(QW-15){1'b0}}, cfg_i.division, {swzt_pkg::QUARTER_SHIFT{1'b0}}};
  assign net_ext = {net_q[QW-1], net_q};
  assign zero_in = (net_ext > -lim64_s) && (net_ext < lim64_s);

  // Round half up towards zero, saturate to 32 bits
  logic signed [32:0] rnd_u;
  logic signed [31:0] rnd_w;
  logic               rnd_corr;
  assign rnd_corr = acc_q[QW] && (acc_q[7:0] != 8'd0);
  assign rnd_u    = acc_q[QW:8] + {32'd0, rnd_corr};
  assign rnd_w    = (rnd_u[32] != rnd_u[31]) ?
                    (rnd_u[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : rnd_u[31:0];

  // Weight compares
  logic signed [32:0] w_ext, lim_hi_s, lim_lo_neg, sr_s, band_s;
  assign w_ext      = {res_q.weight[31], res_q.weight};
  assign lim_hi_s   = {8'd0, lim_hi_q};
  assign lim_lo_neg = 33'sd0 - {18'd0, lim_lo_q};
  assign sr_s       = {9'd0, cfg_i.second_range};
  assign band_s     = {8'd0, prod[swzt_pkg::BAND_W-1:0]};

  // Window entry times ten against the tracking limit
  logic signed [43:0] e_ext, e10, lim10_s;
  logic               in_band;
  assign e_ext   = {{4{rd_data[QW-1]}}, rd_data};
  assign e10     = (e_ext <<< 3) + (e_ext <<< 1);
  assign lim10_s = {19'd0, lim10_q};
  assign in_band = (e10 < lim10_s) && (e10 > -lim10_s);

  logic track_off;
  assign track_off = (cfg_i.track_range == 7'd0) ||
                     (cfg_i.track_range >= swzt_pkg::TRACK_RANGE_MAX);

  logic zero_ok;
  assign zero_ok = stable_q && ((cfg_i.capacity == 24'd0) || (w_ext < band_s));

  // Next state and datapath control
  always_comb begin
    state_d  = state_q;
    zo_d     = zo_q;
    net_d    = net_q;
    ptr_d    = ptr_q;
    filled_d = filled_q;
    warm_d   = warm_q;
    res_d    = res_q;
    code_d   = code_q;
    diff_d   = diff_q;
    stable_d = stable_q;
    acc_d    = acc_q;
    lim_hi_d = lim_hi_q;
    lim_lo_d = lim_lo_q;
    lim10_d  = lim10_q;
    ok_d     = ok_q;
    idx_d    = idx_q;
    mul_a    = '0;
    mul_b    = '0;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    rd_addr  = '0;
    ctl_o    = '0;

    unique case (state_q)
      swzt_pkg::S_IDLE: begin
        ctl_o.idle = 1'b1;
        if (start_i) begin
          code_d   = item_i.adc_code;
          stable_d = item_i.stable;
          diff_d   = {item_i.adc_code[23], item_i.adc_code} -
                     {cfg_i.cal_offset[23], cfg_i.cal_offset};
          idx_d    = '0;
          unique case (item_i.opcode)
            swzt_pkg::OP_SAMPLE: state_d = swzt_pkg::S_SMP_MUL;
            swzt_pkg::OP_TRACK: begin
              if (track_off) begin
                res_d.tracked = 1'b0;
                state_d       = swzt_pkg::S_DONE;
              end else begin
                state_d = filled_q ? swzt_pkg::S_WRITE : swzt_pkg::S_FILL;
              end
            end
            swzt_pkg::OP_ZERO: state_d = swzt_pkg::S_ZDIV;
            default: state_d = swzt_pkg::S_DONE;
          endcase
        end
      end

      // Sample: (code - offset) * gain, warm-up count, converter range
      swzt_pkg::S_SMP_MUL: begin
        mul_a = {{(MW-25){diff_q[24]}}, diff_q};
        mul_b = {cfg_i.cal_gain[31], cfg_i.cal_gain};
        if (warm_q != '0) begin
          warm_d = warm_q - WARM_W'(1);
        end else begin
          res_d.ready_res = 1'b1;
        end
        res_d.adc_over = (code_q > swzt_pkg::ADC_LIMIT) || (code_q < -swzt_pkg::ADC_LIMIT);
        state_d = swzt_pkg::S_SMP_CAL;
      end

      swzt_pkg::S_SMP_CAL: begin
        acc_d   = {cal_sum[55], cal_sum[55:16]};
        mul_a   = MW'(cfg_i.division);
        mul_b   = MW'(swzt_pkg::OVER_DIVS);
        state_d = swzt_pkg::S_SMP_NET;
      end

      swzt_pkg::S_SMP_NET: begin
        net_d    = swzt_pkg::sat_q8(net_diff);
        lim_hi_d = {1'b0, cfg_i.capacity} + {11'd0, prod[13:0]};
        mul_a    = MW'(cfg_i.division);
        mul_b    = MW'(swzt_pkg::UNDER_DIVS);
        state_d  = swzt_pkg::S_SMP_RND;
      end

      swzt_pkg::S_SMP_RND: begin
        lim_lo_d        = prod[14:0];
        res_d.zero_flag = stable_q && zero_in;
        acc_d           = net_ext + (QW+1)'(swzt_pkg::HALF_UNIT);
        state_d         = swzt_pkg::S_SMP_SAT;
      end

      swzt_pkg::S_SMP_SAT: begin
        res_d.weight = rnd_w;
        state_d      = swzt_pkg::S_SMP_FLG;
      end

      swzt_pkg::S_SMP_FLG: begin
        res_d.gross_over  = w_ext > lim_hi_s;
        res_d.gross_under = w_ext < lim_lo_neg;
        res_d.high_range  = (cfg_i.second_range != 24'd0) && (w_ext > sr_s);
        state_d           = swzt_pkg::S_DONE;
      end

      // Tick: fill the whole window on first use
      swzt_pkg::S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        if (idx_q == LAST_IDX) begin
          filled_d = 1'b1;
          state_d  = swzt_pkg::S_WRITE;
        end else begin
          idx_d = idx_q + PW'(1);
        end
      end

      // Tick: push the net weight, start the limit product
      swzt_pkg::S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        ptr_d   = (ptr_q == LAST_IDX) ? '0 : ptr_q + PW'(1);
        mul_a   = MW'(cfg_i.track_range);
        mul_b   = MW'(cfg_i.division);
        state_d = swzt_pkg::S_LIM;
      end

      swzt_pkg::S_LIM: begin
        lim10_d = {prod[16:0], 8'd0};
        rd_addr = '0;
        idx_d   = '0;
        ok_d    = 1'b1;
        state_d = swzt_pkg::S_SCAN;
      end

      // Walk the window, one entry a cycle
      swzt_pkg::S_SCAN: begin
        ok_d    = ok_q && in_band;
        rd_addr = (idx_q == LAST_IDX) ? '0 : idx_q + PW'(1);
        if (idx_q == LAST_IDX) begin
          state_d = swzt_pkg::S_TRK_ADD;
        end else begin
          idx_d = idx_q + PW'(1);
        end
      end

      swzt_pkg::S_TRK_ADD: begin
        if (ok_q && stable_q) begin
          zo_d = swzt_pkg::sat_q8(zo_sum);
        end
        res_d.tracked = ok_q && stable_q;
        state_d       = swzt_pkg::S_DONE;
      end

      // Zero request: band = (capacity / 100) * percent
      swzt_pkg::S_ZDIV: begin
        mul_a   = MW'(cfg_i.capacity);
        mul_b   = MW'(swzt_pkg::RECIP_100);
        state_d = swzt_pkg::S_ZBAND;
      end

      swzt_pkg::S_ZBAND: begin
        mul_a   = MW'(prod[swzt_pkg::RECIP_SHIFT +: swzt_pkg::ZB_Q_W]);
        mul_b   = MW'(cfg_i.zero_band_percent);
        state_d = swzt_pkg::S_ZCMP;
      end

      swzt_pkg::S_ZCMP: begin
        if (zero_ok) begin
          zo_d = swzt_pkg::sat_q8(zo_sum);
        end
        res_d.zero_refused = !zero_ok;
        state_d            = swzt_pkg::S_DONE;
      end

      // Hand the result over once the output slot is free
      swzt_pkg::S_DONE: begin
        if (out_free_i) begin
          ctl_o.fin = 1'b1;
          state_d   = swzt_pkg::S_IDLE;
        end
      end

      default: state_d = swzt_pkg::S_IDLE;
    endcase
  end

  // Sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swzt_pkg::S_IDLE;
      zo_q     <= '0;
      net_q    <= '0;
      ptr_q    <= '0;
      filled_q <= 1'b0;
      warm_q   <= WARM_INIT;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      zo_q     <= zo_d;
      net_q    <= net_d;
      ptr_q    <= ptr_d;
      filled_q <= filled_d;
      warm_q   <= warm_d;
      res_q    <= res_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    diff_q   <= diff_d;
    stable_q <= stable_d;
    acc_q    <= acc_d;
    lim_hi_q <= lim_hi_d;
    lim_lo_q <= lim_lo_d;
    lim10_q  <= lim10_d;
    ok_q     <= ok_d;
    idx_q    <= idx_d;
  end

  assign res_o = res_q;

  `SWZT_ASSERT(a_fill_once, state_q == swzt_pkg::S_FILL |-> !filled_q, "window refilled")
  `SWZT_ASSERT(a_ready_after_warmup, res_q.ready_res |-> (warm_q == '0), "ready before warm-up")
  `SWZT_ASSERT_NEXT(a_offset_hold, !(state_q == swzt_pkg::S_TRK_ADD || state_q == swzt_pkg::S_ZCMP), $stable(zo_q), "zero offset moved outside tick or request")

endmodule

FILE: design/scale_weight_zero_tracker.sv
// Load-cell front end: calibrates converter samples to net weight, tracks and sets
// zero, and reports weight with status flags, one result beat per command beat.
// Commands are taken one at a time. The first enabled zero tracking tick also
// fills the window; a disabled tick or an unused opcode goes straight to the
// result. The sequencer steps one shared multiplier through calibration, limits
// and the zero band, and walks the window store's single read port one entry per
// cycle. A result waiting on the output does not hold off the next command; a
// command finishing while it still waits stalls in place.
// No clearing pass after reset. Registers may be written whenever the block is idle.
`include "scale_weight_zero_tracker_defines.svh"

module scale_weight_zero_tracker #(
  parameter int unsigned TRACK_DEPTH    = swzt_pkg::TRACK_DEPTH_DEF,
  parameter int unsigned WARMUP_SAMPLES = swzt_pkg::WARMUP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swzt_in_if.sink    in_if,
  swzt_out_if.source out_if,
  swzt_cfg_if.sink   cfg_if
);

  swzt_pkg::cfg_t      cfg_q, cfg_d;
  swzt_pkg::in_item_t  item;
  swzt_pkg::core_ctl_t ctl;
  swzt_pkg::result_t   res, out_q;
  logic                out_valid_q;
  logic                out_free;

  // Decode register writes
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        swzt_pkg::REG_CAL_OFFSET:   cfg_d.cal_offset        = cfg_if.data[23:0];
        swzt_pkg::REG_CAL_GAIN:     cfg_d.cal_gain          = cfg_if.data[31:0];
        swzt_pkg::REG_DIVISION:     cfg_d.division          = cfg_if.data[9:0];
        swzt_pkg::REG_CAPACITY:     cfg_d.capacity          = cfg_if.data[23:0];
        swzt_pkg::REG_ZERO_BAND:    cfg_d.zero_band_percent = cfg_if.data[6:0];
        swzt_pkg::REG_TRACK_RANGE:  cfg_d.track_range       = cfg_if.data[6:0];
        swzt_pkg::REG_SECOND_RANGE: cfg_d.second_range      = cfg_if.data[23:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= swzt_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Command beat into the sequencer
  assign item.opcode   = in_if.opcode;
  assign item.adc_code = in_if.adc_code;
  assign item.stable   = in_if.stable;
  assign in_if.ready   = ctl.idle;
  assign out_free      = !out_valid_q || out_if.ready;

  swzt_core #(
    .TRACK_DEPTH    (TRACK_DEPTH),
    .WARMUP_SAMPLES (WARMUP_SAMPLES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_if.valid && in_if.ready),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .res_o      (res)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fin) begin
      out_q <= res;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.weight       = out_q.weight;
  assign out_if.zero_flag    = out_q.zero_flag;
  assign out_if.adc_over     = out_q.adc_over;
  assign out_if.gross_over   = out_q.gross_over;
  assign out_if.gross_under  = out_q.gross_under;
  assign out_if.high_range   = out_q.high_range;
  assign out_if.ready_res    = out_q.ready_res;
  assign out_if.tracked      = out_q.tracked;
  assign out_if.zero_refused = out_q.zero_refused;

  `SWZT_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready, "command taken while busy")

endmodule
